FILE: hdl/counter_priority_task_scheduler_unit_assert.svh
// ---------------------------------------------------------------------------
// Scheduler assertion macros
// Concurrent assertion wrappers clocked on clk, disabled while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef COUNTER_PRIORITY_TASK_SCHEDULER_UNIT_ASSERT_SVH
`define COUNTER_PRIORITY_TASK_SCHEDULER_UNIT_ASSERT_SVH

// Condition must hold on every clock edge.
`define CPTS_ASSERT_ALWAYS(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("scheduler assertion failed");

// Consequent must hold on the edge after the antecedent.
`define CPTS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("scheduler assertion failed");

`endif

FILE: hdl/cpts_pkg.sv
// ---------------------------------------------------------------------------
// Scheduler package
// Command and status codes, slot entry layout and recharge arithmetic.
// ---------------------------------------------------------------------------
package cpts_pkg;

	typedef enum logic [2:0] {
		CMD_TICK    = 3'd0,
		CMD_YIELD   = 3'd1,
		CMD_CREATE  = 3'd2,
		CMD_PDIS    = 3'd3,
		CMD_PEN     = 3'd4,
		CMD_SET_RUN = 3'd5
	} cpts_cmd_t;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_BAD  = 2'd2;

	localparam logic [8:0] COUNTER_MAX = 9'd511;
	localparam logic [7:0] PREEMPT_MAX = 8'd255;

	typedef struct packed {
		logic       running;
		logic       fresh;
		logic [7:0] preempt;
		logic [8:0] counter;
		logic [7:0] prio;
	} cpts_entry_t;

	typedef struct packed {
		logic        found;
		cpts_entry_t entry;
	} cpts_best_t;

	// counter/2 + priority, saturating
	function automatic logic [8:0] cpts_recharge(input logic [8:0] counter,
	                                             input logic [7:0] prio);
		logic [9:0] sum;
		sum = {2'b00, counter[8:1]} + {2'b00, prio};
		return sum[9] ? COUNTER_MAX : sum[8:0];
	endfunction

endpackage

FILE: hdl/cpts_ram.sv
// ---------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module cpts_ram #(
	parameter int WIDTH = 27,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: hdl/cpts_pick.sv
// ---------------------------------------------------------------------------
// Best-slot tracker
// Shared compare unit: keep the loaded slot with the largest counter.
// ---------------------------------------------------------------------------
module cpts_pick
	import cpts_pkg::*;
#(
	parameter int IDX_W = 6
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             clear,
	input  logic             load,
	input  logic [IDX_W-1:0] idx,
	input  cpts_entry_t      entry,
	output cpts_best_t       best,
	output logic [IDX_W-1:0] best_idx
);

	logic             found_q;
	cpts_entry_t      entry_q;
	logic [IDX_W-1:0] idx_q;

	// strict greater keeps the lowest index on a tie
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (clear) begin
			found_q <= 1'b0;
		end else if (load && (!found_q || entry.counter > entry_q.counter)) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!clear && load && (!found_q || entry.counter > entry_q.counter)) begin
			entry_q <= entry;
			idx_q   <= idx;
		end
	end

	assign best.found = found_q;
	assign best.entry = entry_q;
	assign best_idx   = idx_q;

endmodule

FILE: hdl/counter_priority_task_scheduler_unit.sv
// ---------------------------------------------------------------------------
// Counter-based priority task scheduler
// Task table in RAM, one command per item, sequenced slot scans.
// ---------------------------------------------------------------------------
// Usage:
//   Command channel: present cmd, task_index and running_flag with start;
//   the item is taken on a clock edge with start high and busy low.
//   Result channel: done is high for exactly one cycle with current_task,
//   switched, new_task and status; the receiver cannot stall it, so sample
//   the result in that cycle. busy is already low in the done cycle, so the
//   next item may be issued alongside it.
//   Configuration: cfg_write with cfg_data sets initial_priority, which is
//   also the live priority of slot 0. Write only while the block is idle.
// Sequence: a command that does not reschedule passes READ and EXEC and
//   finishes from EXEC. A reschedule goes on from EXEC to a SCAN pass
//   over the N live tasks (slot 0 included), then CHECK and DISP; when
//   every runnable counter is zero, CHECK starts a RECHG pass over the
//   live tasks before DISP. The scan and the recharge pass are bound by
//   the single RAM read port: each visits one slot per cycle through one
//   compare unit.
// Reset: one cycle after reset is spent writing slot 0 into the table;
//   busy is high meanwhile. Other slots are written by create before use.
// ---------------------------------------------------------------------------
`include "counter_priority_task_scheduler_unit_assert.svh"

module counter_priority_task_scheduler_unit
	import cpts_pkg::*;
#(
	parameter int TASK_SLOTS = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [2:0] cmd,
	input  logic [5:0] task_index,
	input  logic       running_flag,
	output logic       done,
	output logic [5:0] current_task,
	output logic       switched,
	output logic [5:0] new_task,
	output logic [1:0] status,
	input  logic       cfg_write,
	input  logic [7:0] cfg_data
);

	localparam int AW = $clog2(TASK_SLOTS);
	localparam int CW = $clog2(TASK_SLOTS + 1);
	localparam int XW = (CW > 6) ? CW : 6;
	localparam int EW = $bits(cpts_entry_t);

	typedef enum logic [7:0] {
		S_INIT  = 8'b0000_0001,
		S_IDLE  = 8'b0000_0010,
		S_READ  = 8'b0000_0100,
		S_EXEC  = 8'b0000_1000,
		S_SCAN  = 8'b0001_0000,
		S_CHECK = 8'b0010_0000,
		S_RECHG = 8'b0100_0000,
		S_DISP  = 8'b1000_0000
	} state_t;

	state_t        state_q;
	logic [2:0]    cmd_q;
	logic [5:0]    idx_q;
	logic          flag_q;
	logic [CW-1:0] k_q;
	logic [AW-1:0] cur_q;
	logic [CW-1:0] tcnt_q;
	logic [7:0]    init_prio_q;
	logic [AW-1:0] raddr_q;
	logic          done_q;
	logic          switched_q;
	logic [5:0]    new_task_q;
	logic [1:0]    status_q;

	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	cpts_entry_t   ram_wdata;
	logic [AW-1:0] ram_raddr;
	logic [EW-1:0] ram_rdata;

	cpts_entry_t   rd_eff;
	cpts_entry_t   rc_entry;
	cpts_entry_t   cand;
	cpts_entry_t   wr_entry;
	logic          pick_clear;
	logic          pick_load;
	cpts_best_t    best;
	logic [AW-1:0] best_idx;
	logic [AW-1:0] next_slot;
	logic          resched;
	logic          create_ok;
	logic [1:0]    ex_status;
	logic          tbl_full;
	logic [8:0]    tick_cnt;

	cpts_ram #(
		.WIDTH (EW),
		.DEPTH (TASK_SLOTS)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	cpts_pick #(
		.IDX_W (AW)
	) u_pick (
		.clk      (clk),
		.arst_n   (arst_n),
		.clear    (pick_clear),
		.load     (pick_load),
		.idx      (raddr_q),
		.entry    (cand),
		.best     (best),
		.best_idx (best_idx)
	);

	// Slot 0 priority lives in the configuration register, not the table.
	always_comb begin
		rd_eff = ram_rdata;
		if (raddr_q == '0) begin
			rd_eff.prio = init_prio_q;
		end
	end

	always_comb begin
		rc_entry         = rd_eff;
		rc_entry.counter = cpts_recharge(rd_eff.counter, rd_eff.prio);
	end

	assign cand       = (state_q == S_RECHG) ? rc_entry : rd_eff;
	assign pick_clear = (state_q == S_SCAN || state_q == S_RECHG) && (k_q == '0);
	assign pick_load  = (state_q == S_SCAN || state_q == S_RECHG) && (k_q != '0)
	                    && cand.running;
	assign next_slot  = best.found ? best_idx : '0;
	assign tbl_full   = (tcnt_q >= CW'(TASK_SLOTS));
	assign tick_cnt   = (rd_eff.counter == '0) ? '0 : rd_eff.counter - 9'd1;

	// Table port control and per-command update
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = raddr_q;
		ram_wdata = rd_eff;
		ram_raddr = cur_q;
		wr_entry  = rd_eff;
		resched   = 1'b0;
		create_ok = 1'b0;
		ex_status = ST_OK;
		unique case (state_q)
			S_INIT: begin
				ram_we            = 1'b1;
				ram_waddr         = '0;
				ram_wdata         = '0;
				ram_wdata.running = 1'b1;
			end
			S_READ: begin
				ram_raddr = (cmd_q == CMD_SET_RUN) ? AW'(idx_q) : cur_q;
			end
			S_EXEC: begin
				unique case (cmd_q)
					CMD_TICK: begin
						ram_we           = 1'b1;
						wr_entry.counter = tick_cnt;
						resched          = (tick_cnt == '0) && (rd_eff.preempt == '0);
					end
					CMD_YIELD: begin
						ram_we           = 1'b1;
						wr_entry.counter = '0;
						resched          = 1'b1;
					end
					CMD_CREATE: begin
						if (tbl_full) begin
							ex_status = ST_FULL;
						end else begin
							create_ok        = 1'b1;
							ram_we           = 1'b1;
							ram_waddr        = tcnt_q[AW-1:0];
							wr_entry.running = 1'b1;
							wr_entry.fresh   = 1'b1;
							wr_entry.preempt = 8'd1;
							wr_entry.counter = {1'b0, rd_eff.prio};
							wr_entry.prio    = rd_eff.prio;
						end
					end
					CMD_PDIS: begin
						ram_we = 1'b1;
						if (rd_eff.preempt != PREEMPT_MAX) begin
							wr_entry.preempt = rd_eff.preempt + 8'd1;
						end
					end
					CMD_PEN: begin
						ram_we = 1'b1;
						if (rd_eff.preempt != '0) begin
							wr_entry.preempt = rd_eff.preempt - 8'd1;
						end
					end
					CMD_SET_RUN: begin
						if (XW'(idx_q) >= XW'(tcnt_q)) begin
							ex_status = ST_BAD;
						end else begin
							ram_we           = 1'b1;
							wr_entry.running = flag_q;
						end
					end
					default: begin
					end
				endcase
				ram_wdata = wr_entry;
			end
			S_SCAN: begin
				ram_raddr = k_q[AW-1:0];
			end
			S_RECHG: begin
				// read slot k, write back slot k-1 recharged
				ram_raddr = k_q[AW-1:0];
				ram_we    = (k_q != '0);
				ram_wdata = rc_entry;
			end
			S_DISP: begin
				// first dispatch: drop the fresh mark and the create-time preempt
				if (next_slot != cur_q && best.found && best.entry.fresh) begin
					ram_we            = 1'b1;
					ram_waddr         = next_slot;
					wr_entry          = best.entry;
					wr_entry.fresh    = 1'b0;
					if (best.entry.preempt != '0) begin
						wr_entry.preempt = best.entry.preempt - 8'd1;
					end
					ram_wdata         = wr_entry;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			cur_q       <= '0;
			tcnt_q      <= CW'(1);
			init_prio_q <= 8'd1;
			k_q         <= '0;
			done_q      <= 1'b0;
			switched_q  <= 1'b0;
			new_task_q  <= '0;
			status_q    <= ST_OK;
		end else begin
			if (cfg_write) begin
				init_prio_q <= cfg_data;
			end
			done_q     <= 1'b0;
			switched_q <= 1'b0;
			unique case (state_q)
				S_INIT: begin
					state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (start) begin
						state_q <= S_READ;
					end
				end
				S_READ: begin
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					k_q <= '0;
					if (resched) begin
						state_q <= S_SCAN;
					end else begin
						// finish here: no reschedule
						done_q     <= 1'b1;
						status_q   <= ex_status;
						new_task_q <= create_ok ? 6'(tcnt_q) : '0;
						if (create_ok) begin
							tcnt_q <= tcnt_q + CW'(1);
						end
						state_q <= S_IDLE;
					end
				end
				S_SCAN: begin
					k_q <= k_q + CW'(1);
					if (k_q == tcnt_q) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					k_q <= '0;
					// all runnable counters spent: recharge once and pick again
					if (best.found && best.entry.counter == '0) begin
						state_q <= S_RECHG;
					end else begin
						state_q <= S_DISP;
					end
				end
				S_RECHG: begin
					k_q <= k_q + CW'(1);
					if (k_q == tcnt_q) begin
						state_q <= S_DISP;
					end
				end
				S_DISP: begin
					if (next_slot != cur_q) begin
						cur_q      <= next_slot;
						switched_q <= 1'b1;
					end
					done_q     <= 1'b1;
					status_q   <= ST_OK;
					new_task_q <= '0;
					state_q    <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Register the read address; latch the command on acceptance, payload only.
	always_ff @(posedge clk) begin
		raddr_q <= ram_raddr;
		if (state_q == S_IDLE && start) begin
			cmd_q  <= cmd;
			idx_q  <= task_index;
			flag_q <= running_flag;
		end
	end

	assign busy         = (state_q != S_IDLE);
	assign done         = done_q;
	assign current_task = 6'(cur_q);
	assign switched     = switched_q;
	assign new_task     = new_task_q;
	assign status       = status_q;

	`CPTS_ASSERT_ALWAYS(a_done_idle, !done_q || state_q == S_IDLE)
	`CPTS_ASSERT_NEXT(a_done_single, done_q, !done_q)
	`CPTS_ASSERT_ALWAYS(a_tcnt_range, tcnt_q != '0 && tcnt_q <= CW'(TASK_SLOTS))
	`CPTS_ASSERT_ALWAYS(a_cur_valid, CW'(cur_q) < tcnt_q)
	`CPTS_ASSERT_ALWAYS(a_switch_strobe, !switched_q || done_q)

endmodule

FILE: test/counter_priority_task_scheduler_unit_test.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Counter priority task scheduler testbench
// Drives scheduler commands with bursty timing, mirrors the task table in a
// tracker object and compares every dispatch result against its prediction.
// ---------------------------------------------------------------------------
module counter_priority_task_scheduler_unit_test
	import cpts_pkg::*;
;

	localparam int TASK_SLOTS     = 64;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 150;

	// Command codes the block decodes as no-ops
	localparam logic [2:0] CMD_SPARE_LO = 3'd6;
	localparam logic [2:0] CMD_SPARE_HI = 3'd7;

	typedef struct {
		logic [5:0] current_task;
		logic       switched;
		logic [5:0] new_task;
		logic [1:0] status;
	} dispatch_outcome_t;

	// Mirror of the task table: predicts the dispatch outcome of each command
	// and holds the outcomes still owed by the block.
	class dispatch_tracker;
		logic              valid   [TASK_SLOTS];
		logic              running [TASK_SLOTS];
		logic              fresh   [TASK_SLOTS];
		logic [8:0]        counter [TASK_SLOTS];
		logic [7:0]        prio    [TASK_SLOTS];
		logic [7:0]        preempt [TASK_SLOTS];
		logic [5:0]        cur_slot;
		int                task_count;
		int                error_count;
		dispatch_outcome_t pending_outcomes[$];

		function new();
			for (int i = 0; i < TASK_SLOTS; i++) begin
				valid[i]   = 1'b0;
				running[i] = 1'b0;
				fresh[i]   = 1'b0;
				counter[i] = '0;
				prio[i]    = '0;
				preempt[i] = '0;
			end
			valid[0]    = 1'b1;
			running[0]  = 1'b1;
			prio[0]     = 8'd1;
			cur_slot    = '0;
			task_count  = 1;
			error_count = 0;
		endfunction

		function void apply_priority(logic [7:0] value);
			prio[0] = value;
		endfunction

		function int pending();
			return pending_outcomes.size();
		endfunction

		// Runnable slot with the largest counter, lowest index on a tie
		function logic [5:0] best_runnable(output int best);
			logic [5:0] pick;
			pick = '0;
			best = -1;
			for (int i = 0; i < TASK_SLOTS; i++) begin
				if (valid[i] && running[i] && int'(counter[i]) > best) begin
					best = int'(counter[i]);
					pick = 6'(i);
				end
			end
			return pick;
		endfunction

		function void reschedule();
			int         top;
			int         sum;
			logic [5:0] nxt;
			nxt = best_runnable(top);
			if (top == 0) begin
				// Every runnable slice spent: recharge all live tasks once
				for (int i = 0; i < TASK_SLOTS; i++) begin
					if (valid[i]) begin
						sum = int'(counter[i] >> 1) + int'(prio[i]);
						counter[i] = (sum > int'(COUNTER_MAX)) ? COUNTER_MAX : 9'(sum);
					end
				end
				nxt = best_runnable(top);
			end
			if (nxt != cur_slot) begin
				cur_slot = nxt;
				if (fresh[nxt]) begin
					fresh[nxt] = 1'b0;
					if (preempt[nxt] != 0)
						preempt[nxt] = preempt[nxt] - 8'd1;
				end
			end
		endfunction

		function void note_command(logic [2:0] op, logic [5:0] idx, logic flag);
			dispatch_outcome_t res;
			logic [5:0]        prior;
			prior        = cur_slot;
			res.new_task = '0;
			res.status   = ST_OK;
			case (op)
				CMD_TICK: begin
					if (counter[cur_slot] != 0)
						counter[cur_slot] = counter[cur_slot] - 9'd1;
					if (counter[cur_slot] == 0 && preempt[cur_slot] == 0)
						reschedule();
				end
				CMD_YIELD: begin
					counter[cur_slot] = '0;
					reschedule();
				end
				CMD_CREATE: begin
					if (task_count >= TASK_SLOTS) begin
						res.status = ST_FULL;
					end else begin
						valid[task_count]   = 1'b1;
						running[task_count] = 1'b1;
						prio[task_count]    = prio[cur_slot];
						counter[task_count] = {1'b0, prio[cur_slot]};
						preempt[task_count] = 8'd1;
						fresh[task_count]   = 1'b1;
						res.new_task        = 6'(task_count);
						task_count++;
					end
				end
				CMD_PDIS: begin
					if (preempt[cur_slot] != PREEMPT_MAX)
						preempt[cur_slot] = preempt[cur_slot] + 8'd1;
				end
				CMD_PEN: begin
					if (preempt[cur_slot] != 0)
						preempt[cur_slot] = preempt[cur_slot] - 8'd1;
				end
				CMD_SET_RUN: begin
					if (!valid[idx])
						res.status = ST_BAD;
					else
						running[idx] = flag;
				end
				default: ;
			endcase
			res.current_task = cur_slot;
			res.switched     = (cur_slot != prior);
			pending_outcomes.push_back(res);
		endfunction

		function void check_outcome(logic [5:0] cur_t, logic sw, logic [5:0] nt,
		                            logic [1:0] st);
			dispatch_outcome_t want;
			if (pending_outcomes.size() == 0) begin
				$error("result with no command outstanding: current_task %0d", cur_t);
				error_count++;
				return;
			end
			want = pending_outcomes.pop_front();
			if (cur_t !== want.current_task) begin
				$error("current_task: expected %0d, got %0d", want.current_task, cur_t);
				error_count++;
			end
			if (sw !== want.switched) begin
				$error("switched: expected %0d, got %0d", want.switched, sw);
				error_count++;
			end
			if (nt !== want.new_task) begin
				$error("new_task: expected %0d, got %0d", want.new_task, nt);
				error_count++;
			end
			if (st !== want.status) begin
				$error("status: expected %0d, got %0d", want.status, st);
				error_count++;
			end
		endfunction
	endclass

	logic       clk          = 1'b0;
	logic       arst_n       = 1'b0;
	logic       start        = 1'b0;
	logic       busy;
	logic [2:0] cmd          = '0;
	logic [5:0] task_index   = '0;
	logic       running_flag = 1'b0;
	logic       done;
	logic [5:0] current_task;
	logic       switched;
	logic [5:0] new_task;
	logic [1:0] status;
	logic       cfg_write    = 1'b0;
	logic [7:0] cfg_data     = '0;

	dispatch_tracker tracker;
	int              items_sent = 0;
	int              burst_left = 0;

	counter_priority_task_scheduler_unit #(
		.TASK_SLOTS(TASK_SLOTS)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.cmd          (cmd),
		.task_index   (task_index),
		.running_flag (running_flag),
		.done         (done),
		.current_task (current_task),
		.switched     (switched),
		.new_task     (new_task),
		.status       (status),
		.cfg_write    (cfg_write),
		.cfg_data     (cfg_data)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// Results last one cycle and cannot be held off: take each one at the
	// edge that closes its done cycle.
	always @(posedge clk) begin
		if (arst_n && done)
			tracker.check_outcome(current_task, switched, new_task, status);
	end

	// Issue one command and hold it until the block takes it. Start is left
	// high on return so that a following item can go out back to back; this
	// task drops it only when a gap is due.
	task automatic issue_item(logic [2:0] op, logic [5:0] idx, logic flag);
		int gap;
		if (burst_left == 0) begin
			// Close the burst: idle for a random gap, sometimes none at all
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap != 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		cmd          <= op;
		task_index   <= idx;
		running_flag <= flag;
		start        <= 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);
		tracker.note_command(op, idx, flag);
		items_sent++;
	endtask

	// Any command but set-run, with random noise on the fields that it ignores
	task automatic issue_noisy(logic [2:0] op);
		issue_item(op, 6'($urandom), 1'($urandom));
	endtask

	// Drop start and let every owed result arrive before touching the register
	task automatic wait_idle();
		start <= 1'b0;
		while (tracker.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_initial_priority(logic [7:0] value);
		wait_idle();
		cfg_data  <= value;
		cfg_write <= 1'b1;
		@(posedge clk);
		cfg_write <= 1'b0;
		tracker.apply_priority(value);
		@(posedge clk);
	endtask

	task automatic issue_random_command(int create_pct);
		logic [2:0] op;
		logic [5:0] idx;
		logic       flag;
		int         pick;
		idx  = 6'($urandom);
		flag = 1'($urandom);
		if ($urandom_range(0, 99) < create_pct) begin
			op = CMD_CREATE;
		end else begin
			pick = $urandom_range(0, 99);
			if (pick < 40)
				op = CMD_TICK;
			else if (pick < 52)
				op = CMD_YIELD;
			else if (pick < 62)
				op = CMD_PDIS;
			else if (pick < 74)
				op = CMD_PEN;
			else if (pick < 94)
				op = CMD_SET_RUN;
			else
				op = $urandom_range(0, 1) ? CMD_SPARE_HI : CMD_SPARE_LO;
		end
		if (op == CMD_SET_RUN) begin
			// Mostly live slots, now and then any index to hit the bad-slot path
			if ($urandom_range(0, 6) != 0)
				idx = 6'($urandom_range(0, tracker.task_count - 1));
			flag = ($urandom_range(0, 99) < 65);
		end
		issue_item(op, idx, flag);
	endtask

	// Random traffic built from short scheduling scenarios
	task automatic random_phase(int count, int create_pct);
		int target;
		int kind;
		int depth;
		logic [5:0] victim;
		target = items_sent + count;
		while (items_sent < target) begin
			kind = $urandom_range(0, 99);
			if (kind < 60) begin
				issue_random_command(create_pct);
			end else if (kind < 75) begin
				// Run of ticks: burn through a time slice
				repeat ($urandom_range(4, 40)) issue_noisy(CMD_TICK);
			end else if (kind < 88) begin
				// Critical section: ticks under preemption disabled
				depth = $urandom_range(1, 6);
				repeat (depth) issue_noisy(CMD_PDIS);
				repeat ($urandom_range(1, 8)) issue_noisy(CMD_TICK);
				repeat (depth) issue_noisy(CMD_PEN);
			end else begin
				// Park a task, let the rest run, then wake it
				victim = 6'($urandom_range(0, tracker.task_count - 1));
				issue_item(CMD_SET_RUN, victim, 1'b0);
				issue_noisy(CMD_YIELD);
				repeat ($urandom_range(0, 6)) issue_noisy(CMD_TICK);
				issue_item(CMD_SET_RUN, victim, 1'b1);
			end
		end
	endtask

	// Abort when nothing moves on either channel for too long
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((start && !busy) || done)
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		tracker = new();

		// Hold reset, then wait out the slot 0 initialisation
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);
		while (busy) @(posedge clk);

		// Directed part at the reset priority of one
		issue_noisy(CMD_TICK);                 // empty slice recharges slot 0
		issue_noisy(CMD_SPARE_LO);
		issue_noisy(CMD_SPARE_HI);
		issue_item(CMD_SET_RUN, 6'd63, 1'b1);  // never-created slot
		issue_item(CMD_SET_RUN, 6'd1, 1'b0);
		issue_noisy(CMD_CREATE);               // slot 1, preemption held once
		issue_noisy(CMD_YIELD);                // first dispatch of slot 1
		issue_noisy(CMD_PDIS);
		issue_noisy(CMD_TICK);                 // slice ends but preemption held
		issue_noisy(CMD_PEN);
		issue_noisy(CMD_PEN);                  // floor at zero
		issue_noisy(CMD_TICK);                 // all spent: recharge, tie to slot 0
		issue_item(CMD_SET_RUN, 6'd0, 1'b0);
		issue_item(CMD_SET_RUN, 6'd1, 1'b0);
		issue_noisy(CMD_YIELD);                // nothing runnable: slot 0
		issue_item(CMD_SET_RUN, 6'd1, 1'b1);
		issue_noisy(CMD_TICK);
		issue_item(CMD_SET_RUN, 6'd0, 1'b1);
		issue_noisy(CMD_CREATE);
		issue_noisy(CMD_CREATE);
		issue_noisy(CMD_CREATE);
		issue_noisy(CMD_YIELD);
		issue_item(CMD_SET_RUN, 6'd4, 1'b1);
		issue_item(CMD_SET_RUN, 6'd5, 1'b1);   // one past the last live slot

		// Drive the preemption count into its ceiling and back to its floor
		set_initial_priority(8'd255);
		repeat (260) issue_noisy(CMD_PDIS);
		repeat (3) issue_noisy(CMD_TICK);
		repeat (260) issue_noisy(CMD_PEN);
		issue_noisy(CMD_TICK);

		// Random phases under several priority settings, creates growing denser
		set_initial_priority(8'd1);
		random_phase(30, 4);
		set_initial_priority(8'($urandom_range(2, 254)));
		random_phase(30, 6);
		set_initial_priority(8'd255);
		random_phase(30, 8);
		set_initial_priority(8'($urandom_range(2, 254)));
		random_phase(30, 10);

		// Fill the table, then keep creating against a full table
		set_initial_priority(8'd1);
		while (tracker.task_count < TASK_SLOTS) issue_noisy(CMD_CREATE);
		issue_noisy(CMD_CREATE);
		issue_noisy(CMD_CREATE);
		random_phase(30, 10);

		// Drain, then linger long enough to catch a stray result
		start <= 1'b0;
		while (tracker.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (tracker.error_count == 0 && tracker.pending() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

FILE: counter_priority_task_scheduler_unit.f
+incdir+hdl
hdl/cpts_pkg.sv
hdl/cpts_ram.sv
hdl/cpts_pick.sv
hdl/counter_priority_task_scheduler_unit.sv
test/counter_priority_task_scheduler_unit_test.sv
